[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with reset disable.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Clocked next-cycle implication with reset disable.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/skvlt_pkg.sv]
// Package with command and status codes of the sorted key/value leaf table.
package skvlt_pkg;
  localparam logic [3:0] CMD_INSERT = 4'd0;
  localparam logic [3:0] CMD_LOOKUP = 4'd1;
  localparam logic [3:0] CMD_REMOVE = 4'd2;
  localparam logic [3:0] CMD_LBOUND = 4'd3;
  localparam logic [3:0] CMD_READ   = 4'd4;
  localparam logic [3:0] CMD_PUSHF  = 4'd5;
  localparam logic [3:0] CMD_PUSHB  = 4'd6;
  localparam logic [3:0] CMD_POPF   = 4'd7;
  localparam logic [3:0] CMD_POPB   = 4'd8;
  localparam logic [3:0] CMD_SPLIT  = 4'd9;
  localparam logic [3:0] CMD_DRAIN  = 4'd10;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_MISS   = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;
  localparam logic [2:0] ST_BADPOS = 3'd5;

  localparam logic CFG_PAGE_LIMIT = 1'b0;
  localparam logic CFG_KEY_SIGNED = 1'b1;
endpackage

[hw/rtl/sorted_key_value_leaf_table.sv]
// Top level of the sorted key/value leaf table.
// The entries sit in one single-port-read memory with a registered read, so a
// key search reads one entry a cycle, and an insert or remove moves one entry
// per read/write cycle. Split and drain emit one entry per cycle as the output
// stage is taken. One command is worked on at a time; the memory needs no
// clearing after reset.
module sorted_key_value_leaf_table #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cmd[3:0], entry_key, entry_value, position[6:0], zero fill
  input  logic [((4+KEY_BITS+VALUE_BITS+7+7)/8)*8-1:0] s_axis_tdata,
  input  logic m_axis_tready,
  output logic m_axis_tvalid,
  // status[2:0], count_after[6:0], out_key, out_value, out_position[6:0], zero fill
  output logic [((17+KEY_BITS+VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_index_i,
  input  logic [5:0] cfg_data_i
);
  localparam int IW = $clog2(CAPACITY);
  localparam int KB = KEY_BITS;
  localparam int VB = VALUE_BITS;
  localparam int OW = ((17+KB+VB+7)/8)*8;
  localparam logic [6:0] CAP = 7'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0, S_SRCH = 3'd1, S_SHIFT = 3'd2,
                         S_EMIT = 3'd3, S_OUT = 3'd4, S_RD = 3'd5;
  logic [2:0] st_q, st_d;

  logic [KB-1:0] kmem [CAPACITY];
  logic [VB-1:0] vmem [CAPACITY];
  logic [KB-1:0] rk_q;
  logic [VB-1:0] rv_q;
  logic re;
  logic [IW-1:0] ra;
  logic we;
  logic [IW-1:0] wa;
  logic [KB-1:0] wk;
  logic [VB-1:0] wv;

  logic [6:0] cnt_q, cnt_d;
  logic [5:0] maxs_q;
  logic       ksg_q;
  logic [3:0] cmd_q;
  logic [KB-1:0] key_q;
  logic [VB-1:0] val_q;
  logic [6:0] pos_q;
  logic [6:0] i_q, i_d;     // scan index
  logic [6:0] j_q, j_d;     // shift / emit index
  logic [6:0] end_q, end_d;
  logic [6:0] keep_q, keep_d;
  logic pend_q, pend_d;     // read data valid this cycle

  logic ov_q, ov_d;
  logic [2:0] ost_q, ost_d;
  logic [6:0] ocnt_q, ocnt_d, opos_q, opos_d;
  logic [KB-1:0] okey_q, okey_d;
  logic [VB-1:0] oval_q, oval_d;
  logic olast_q, olast_d;

  logic [3:0] in_cmd;
  logic [KB-1:0] in_key;
  logic [VB-1:0] in_val;
  logic [6:0] in_pos;
  assign in_cmd = s_axis_tdata[3:0];
  assign in_key = s_axis_tdata[4 +: KB];
  assign in_val = s_axis_tdata[4+KB +: VB];
  assign in_pos = s_axis_tdata[4+KB+VB +: 7];

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata = OW'({opos_q, oval_q, okey_q, ocnt_q, ost_q});

  // Compare with the selected signedness.
  logic [KB-1:0] ka, kb;
  logic k_lt, k_eq;
  always_comb begin
    ka = rk_q ^ {ksg_q, {(KB-1){1'b0}}};
    kb = key_q ^ {ksg_q, {(KB-1){1'b0}}};
    k_lt = ka < kb;
    k_eq = ka == kb;
  end

  // Memory read and write.
  always_ff @(posedge clk_i) begin
    if (we) begin
      kmem[wa] <= wk;
      vmem[wa] <= wv;
    end
    if (re) begin
      rk_q <= kmem[ra];
      rv_q <= vmem[ra];
    end
  end

  // Sequencer.
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; end_d = end_q;
    keep_d = keep_q; pend_d = 1'b0;
    ov_d = ov_q; ost_d = ost_q; ocnt_d = ocnt_q; opos_d = opos_q;
    okey_d = okey_q; oval_d = oval_q; olast_d = olast_q;
    re = 1'b0; ra = i_q[IW-1:0]; we = 1'b0; wa = i_q[IW-1:0];
    wk = key_q; wv = val_q;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          i_d = 7'd0;
          olast_d = 1'b1;
          case (in_cmd)
            skvlt_pkg::CMD_INSERT, skvlt_pkg::CMD_LOOKUP, skvlt_pkg::CMD_REMOVE,
            skvlt_pkg::CMD_LBOUND: begin
              st_d = S_SRCH;
              if (cnt_q != 7'd0) begin
                re = 1'b1; ra = '0; pend_d = 1'b1;
              end
            end
            skvlt_pkg::CMD_READ, skvlt_pkg::CMD_POPF, skvlt_pkg::CMD_POPB: begin
              st_d = S_RD;
              i_d = (in_cmd == skvlt_pkg::CMD_READ) ? in_pos - 7'd1 :
                    (in_cmd == skvlt_pkg::CMD_POPF) ? 7'd0 : cnt_q - 7'd1;
              re = 1'b1; ra = i_d[IW-1:0];
            end
            skvlt_pkg::CMD_PUSHF, skvlt_pkg::CMD_PUSHB: begin
              st_d = S_SRCH;
              i_d = (in_cmd == skvlt_pkg::CMD_PUSHF) ? 7'd0 : cnt_q;
            end
            skvlt_pkg::CMD_SPLIT, skvlt_pkg::CMD_DRAIN: begin
              keep_d = (in_cmd == skvlt_pkg::CMD_SPLIT) ?
                       7'((7'(maxs_q) + 7'd2) >> 1) : 7'd0;
              if (cnt_q <= keep_d) begin
                ov_d = 1'b1; ost_d = skvlt_pkg::ST_EMPTY; ocnt_d = cnt_q;
                okey_d = '0; oval_d = '0; opos_d = 7'd0;
              end else begin
                st_d = S_EMIT; j_d = keep_d; end_d = cnt_q;
                re = 1'b1; ra = keep_d[IW-1:0]; cnt_d = keep_d;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        // One compare per cycle; pend_q marks rk_q as entry i_q.
        if (cmd_q == skvlt_pkg::CMD_PUSHF || cmd_q == skvlt_pkg::CMD_PUSHB) begin
          if (cnt_q >= CAP) begin
            ov_d = 1'b1; ost_d = skvlt_pkg::ST_FULL; ocnt_d = cnt_q;
            okey_d = key_q; oval_d = val_q; opos_d = 7'd0; st_d = S_IDLE;
          end else begin
            st_d = S_SHIFT; j_d = cnt_q; end_d = i_q;
            if (cnt_q != i_q) begin
              re = 1'b1; ra = IW'(cnt_q - 7'd1); pend_d = 1'b1;
            end
          end
        end else if (pend_q && k_lt) begin
          i_d = i_q + 7'd1;
          if (i_d != cnt_q) begin
            re = 1'b1; ra = i_d[IW-1:0]; pend_d = 1'b1;
          end
        end else begin
          // i_q is lower bound; hit when pend_q and equal.
          st_d = S_IDLE; ov_d = 1'b1; ocnt_d = cnt_q; opos_d = i_q + 7'd1;
          ost_d = skvlt_pkg::ST_OK;
          okey_d = pend_q ? rk_q : '0; oval_d = pend_q ? rv_q : '0;
          case (cmd_q)
            skvlt_pkg::CMD_INSERT: begin
              if (pend_q && k_eq) begin
                ost_d = skvlt_pkg::ST_DUP; okey_d = key_q;
              end else if (cnt_q >= CAP) begin
                ost_d = skvlt_pkg::ST_FULL; okey_d = key_q; oval_d = '0;
                opos_d = 7'd0;
              end else begin
                ov_d = 1'b0; st_d = S_SHIFT; j_d = cnt_q; end_d = i_q;
                if (cnt_q != i_q) begin
                  re = 1'b1; ra = IW'(cnt_q - 7'd1); pend_d = 1'b1;
                end
              end
            end
            skvlt_pkg::CMD_LOOKUP, skvlt_pkg::CMD_REMOVE: begin
              if (!(pend_q && k_eq)) begin
                ost_d = skvlt_pkg::ST_MISS; okey_d = key_q; oval_d = '0;
              end else if (cmd_q == skvlt_pkg::CMD_REMOVE) begin
                ov_d = 1'b0; st_d = S_SHIFT; j_d = i_q; end_d = cnt_q - 7'd1;
                if (i_q + 7'd1 != cnt_q) begin
                  re = 1'b1; ra = IW'(i_q + 7'd1); pend_d = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        // Move one entry per read/write pair; open hole upward or close it.
        if (cmd_q == skvlt_pkg::CMD_REMOVE || cmd_q == skvlt_pkg::CMD_POPF) begin
          if (pend_q) begin
            we = 1'b1; wa = j_q[IW-1:0]; wk = rk_q; wv = rv_q;
            j_d = j_q + 7'd1;
            if (j_d != end_q) begin
              re = 1'b1; ra = IW'(j_d + 7'd1); pend_d = 1'b1;
            end
          end else begin
            cnt_d = cnt_q - 7'd1; st_d = S_IDLE; ov_d = 1'b1; ocnt_d = cnt_d;
          end
        end else begin
          if (pend_q) begin
            we = 1'b1; wa = j_q[IW-1:0]; wk = rk_q; wv = rv_q;
            j_d = j_q - 7'd1;
            if (j_d != end_q) begin
              re = 1'b1; ra = IW'(j_d - 7'd1); pend_d = 1'b1;
            end
          end else begin
            we = 1'b1; wa = end_q[IW-1:0];
            cnt_d = cnt_q + 7'd1; st_d = S_IDLE; ov_d = 1'b1; ocnt_d = cnt_d;
            ost_d = skvlt_pkg::ST_OK; okey_d = key_q; oval_d = val_q;
            opos_d = end_q + 7'd1;
          end
        end
      end
      S_RD: begin
        st_d = S_IDLE; ov_d = 1'b1; opos_d = i_q + 7'd1;
        okey_d = rk_q; oval_d = rv_q; ost_d = skvlt_pkg::ST_OK; ocnt_d = cnt_q;
        if (cmd_q == skvlt_pkg::CMD_READ) begin
          opos_d = pos_q;
          if (pos_q == 7'd0 || pos_q > cnt_q) begin
            ost_d = skvlt_pkg::ST_BADPOS; okey_d = '0; oval_d = '0;
          end
        end else if (cnt_q == 7'd0) begin
          ost_d = skvlt_pkg::ST_EMPTY; okey_d = '0; oval_d = '0; opos_d = 7'd0;
        end else if (cmd_q == skvlt_pkg::CMD_POPB) begin
          cnt_d = cnt_q - 7'd1; ocnt_d = cnt_d;
        end else begin
          // Pop front reuses the close-gap shift from entry zero.
          ov_d = 1'b0; st_d = S_SHIFT; j_d = 7'd0; end_d = cnt_q - 7'd1;
          okey_d = rk_q; oval_d = rv_q; opos_d = 7'd1;
          if (cnt_q != 7'd1) begin
            re = 1'b1; ra = IW'(1); pend_d = 1'b1;
          end
        end
      end
      S_EMIT: begin
        // Read data of entry j_q arrives; wait for the output stage.
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1; ost_d = skvlt_pkg::ST_OK; ocnt_d = cnt_q;
          okey_d = rk_q; oval_d = rv_q; opos_d = j_q - keep_q + 7'd1;
          olast_d = (j_q + 7'd1 == end_q);
          j_d = j_q + 7'd1;
          if (olast_d) st_d = S_IDLE;
          else begin
            re = 1'b1; ra = j_d[IW-1:0];
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; ov_q <= 1'b0; pend_q <= 1'b0;
      maxs_q <= 6'd32; ksg_q <= 1'b1;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d; pend_q <= pend_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == skvlt_pkg::CFG_PAGE_LIMIT) maxs_q <= cfg_data_i;
        else ksg_q <= cfg_data_i[0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; end_q <= end_d; keep_q <= keep_d;
    ost_q <= ost_d; ocnt_q <= ocnt_d; opos_q <= opos_d;
    okey_q <= okey_d; oval_q <= oval_d; olast_q <= olast_d;
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= in_cmd; key_q <= in_key; val_q <= in_val; pos_q <= in_pos;
    end
  end
endmodule

[hw/rtl/skvlt_checker.sv]
// Port-level checker for the sorted key/value leaf table, with its bind.
`include "assert_macros.svh"
module skvlt_checker #(
  parameter int OW = 120
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic [OW-1:0] m_axis_tdata
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready,
    "input taken while a result waits")
  `ASSERT_IMPL(a_count_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[9:3] <= 7'd64,
    "count above capacity")
  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd5,
    "status code out of range")
endmodule

bind sorted_key_value_leaf_table skvlt_checker #(.OW(OW)) u_skvlt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata));
